// ===== rtl/core/rtcm3df_pkg.sv =====
// Shared types and constants for the RTCM3 frame deframer.
package rtcm3df_pkg;

    localparam int ERR_CNT_BITS = 16;
    localparam int LEN_BITS     = 10;
    localparam int POS_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 10;

    localparam logic [7:0]          SYNC_BYTE_RST  = 8'hD3;
    localparam logic [LEN_BITS-1:0] MAX_LEN_RST    = 10'd1023;
    localparam logic [7:0]          LEN_HI_MASK    = 8'h03;

    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_BYTE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LEN   = 2'd1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_IGNORED   = 2'd0;
    localparam kind_t KIND_FRAME     = 2'd1;
    localparam kind_t KIND_LAST      = 2'd2;
    localparam kind_t KIND_LEN_ERROR = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LEN2    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CK1     = 3'd4,
        PH_CK2     = 3'd5,
        PH_CK3     = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [LEN_BITS-1:0]     bytes_left;
        logic [POS_BITS-1:0]     position;
        logic [1:0]              len_hi;
        logic [ERR_CNT_BITS-1:0] err_cnt;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]          sync_byte;
        logic [LEN_BITS-1:0] max_len;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          out_byte;
        logic [POS_BITS-1:0] byte_index;
        logic [POS_BITS-1:0] frame_len;
        logic [15:0]         error_total;
    } result_t;

endpackage

// ===== rtl/core/rtcm3df_step.sv =====
// Per-byte parser step: next parser state and result for one received byte.
module rtcm3df_step (
    input  rtcm3df_pkg::parse_state_t state,
    input  rtcm3df_pkg::cfg_t         cfg,
    input  logic [7:0]                data_byte,
    output rtcm3df_pkg::parse_state_t state_next,
    output rtcm3df_pkg::result_t      res
);
    import rtcm3df_pkg::*;

    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] left_dec;
    kind_t               kind;
    logic [7:0]          obyte;
    logic [POS_BITS-1:0] idx;
    logic [POS_BITS-1:0] flen;
    logic [POS_BITS-1:0] pos_base;

    assign len      = {state.len_hi, data_byte};
    assign left_dec = state.bytes_left - LEN_BITS'(1);

    always_comb
    begin
        state_next = state;
        kind       = KIND_FRAME;
        obyte      = data_byte;
        idx        = state.position;
        flen       = '0;
        pos_base   = state.position;

        case (state.phase)
            PH_LEN1:
            begin
                state_next.len_hi = data_byte[1:0] & LEN_HI_MASK[1:0];
                state_next.phase  = PH_LEN2;
            end
            PH_LEN2:
            begin
                if (len > cfg.max_len)
                begin
                    if (state.err_cnt != '1)
                        state_next.err_cnt = state.err_cnt + ERR_CNT_BITS'(1);
                    kind             = KIND_LEN_ERROR;
                    state_next.phase = PH_HUNT;
                end
                else
                begin
                    state_next.bytes_left = len;
                    state_next.phase      = (len == '0) ? PH_CK1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                state_next.bytes_left = left_dec;
                if (left_dec == '0)
                    state_next.phase = PH_CK1;
            end
            PH_CK1:
                state_next.phase = PH_CK2;
            PH_CK2:
                state_next.phase = PH_CK3;
            PH_CK3:
            begin
                kind             = KIND_LAST;
                flen             = state.position + POS_BITS'(1);
                state_next.phase = PH_HUNT;
            end
            default:
            begin
                state_next.phase = PH_HUNT;
                idx              = '0;
                if (data_byte == cfg.sync_byte)
                begin
                    pos_base         = '0;
                    state_next.phase = PH_LEN1;
                end
                else
                begin
                    kind  = KIND_IGNORED;
                    obyte = '0;
                end
            end
        endcase

        // position only runs on through ordinary frame bytes
        if (kind == KIND_FRAME)
            state_next.position = pos_base + POS_BITS'(1);
        else
            state_next.position = '0;

        res.kind        = kind;
        res.out_byte    = obyte;
        res.byte_index  = idx;
        res.frame_len   = flen;
        res.error_total = 16'(state_next.err_cnt);
    end

endmodule

// ===== rtl/core/rtcm3_frame_deframer.sv =====
// Top level of the RTCM3 frame deframer: config, parser state and result register.
//
//  channel  signals                                         direction
//  in       in_valid/in_ready, data_byte                    byte into block
//  out      out_valid/out_ready, kind, out_byte,            result out of block
//           byte_index, frame_len, error_total
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         register write in
//
// One byte per cycle while the output is not stalled: the parser step is evaluated
// on the accepted byte and the result lands in the output register on the same edge.
// A new byte is taken while the held result is being transferred; only a stalled
// output with a full result register holds off input. Reset clears parser state,
// error count and config to defaults. Config writes are always accepted.
module rtcm3_frame_deframer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             data_byte,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             kind,
    output logic [7:0]                             out_byte,
    output logic [rtcm3df_pkg::POS_BITS-1:0]       byte_index,
    output logic [rtcm3df_pkg::POS_BITS-1:0]       frame_len,
    output logic [15:0]                            error_total,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rtcm3df_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rtcm3df_pkg::CFG_DAT_BITS-1:0]   cfg_data
);
    import rtcm3df_pkg::*;

    cfg_t         cfg_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    result_t      res_reg;
    logic         out_valid_reg;
    logic         in_xfer;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    rtcm3df_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .data_byte  (data_byte),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte    <= SYNC_BYTE_RST;
            cfg_reg.max_len      <= MAX_LEN_RST;
            state_reg.phase      <= PH_HUNT;
            state_reg.bytes_left <= '0;
            state_reg.position   <= '0;
            state_reg.len_hi     <= '0;
            state_reg.err_cnt    <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SYNC_BYTE: cfg_reg.sync_byte <= cfg_data[7:0];
                    REG_MAX_LEN:   cfg_reg.max_len   <= cfg_data[LEN_BITS-1:0];
                    default:       ;
                endcase
            end
            if (in_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = res_reg.kind;
    assign out_byte    = res_reg.out_byte;
    assign byte_index  = res_reg.byte_index;
    assign frame_len   = res_reg.frame_len;
    assign error_total = res_reg.error_total;

endmodule

// ===== dv/rtcm3_frame_deframer_test.sv =====
// Self-checking testbench for the RTCM3 frame deframer: directed, random and stress traffic.
module rtcm3_frame_deframer_test;
    import rtcm3df_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SHOWN_ERRORS   = 10;

    // indexes that decode to no register
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [7:0]                data_byte   = 8'h00;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [1:0]                kind;
    logic [7:0]                out_byte;
    logic [POS_BITS-1:0]       byte_index;
    logic [POS_BITS-1:0]       frame_len;
    logic [15:0]               error_total;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index   = '0;
    logic [CFG_DAT_BITS-1:0]   cfg_data    = '0;

    rtcm3_frame_deframer DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser mirror and its copy of the registers
    phase_t                  ph          = PH_HUNT;
    logic [LEN_BITS-1:0]     left_cnt    = '0;
    logic [POS_BITS-1:0]     pos         = '0;
    logic [1:0]              len_hi      = '0;
    logic [ERR_CNT_BITS-1:0] err_cnt     = '0;
    logic [7:0]              cur_sync    = SYNC_BYTE_RST;
    logic [LEN_BITS-1:0]     cur_max_len = MAX_LEN_RST;

    result_t pending_results[$];

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  n_bytes      = 0;
    int  n_frames     = 0;
    int  n_len_errors = 0;
    int  n_cfg_writes = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    bit  rx_hold_req  = 1'b0;

    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t            r;
        logic [LEN_BITS-1:0] len;
        r.kind       = KIND_FRAME;
        r.out_byte   = b;
        r.byte_index = pos;
        r.frame_len  = '0;
        case (ph)
            PH_LEN1:
            begin
                len_hi = b[1:0];
                ph     = PH_LEN2;
            end
            PH_LEN2:
            begin
                len = {len_hi, b};
                if (len > cur_max_len)
                begin
                    if (err_cnt != '1)
                        err_cnt = err_cnt + 1'b1;
                    r.kind = KIND_LEN_ERROR;
                    ph     = PH_HUNT;
                end
                else
                begin
                    left_cnt = len;
                    if (len == '0)
                        ph = PH_CK1;
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                left_cnt = left_cnt - 1'b1;
                if (left_cnt == '0)
                    ph = PH_CK1;
            end
            PH_CK1: ph = PH_CK2;
            PH_CK2: ph = PH_CK3;
            PH_CK3:
            begin
                r.kind      = KIND_LAST;
                r.frame_len = pos + 1'b1;
                ph          = PH_HUNT;
            end
            default:
            begin
                ph = PH_HUNT;
                if (b == cur_sync)
                begin
                    r.byte_index = '0;
                    pos          = '0;
                    ph           = PH_LEN1;
                end
                else
                begin
                    r.kind       = KIND_IGNORED;
                    r.out_byte   = 8'h00;
                    r.byte_index = '0;
                end
            end
        endcase
        if (r.kind == KIND_FRAME)
            pos = pos + 1'b1;
        else
            pos = '0;
        r.error_total = err_cnt;
        return r;
    endfunction

    // result check first, then prediction, so a same-edge pair stays in order
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{kind, out_byte, byte_index, frame_len, error_total};
                if (got.kind == KIND_LAST)
                    n_frames++;
                if (got.kind == KIND_LEN_ERROR)
                    n_len_errors++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("unexpected result kind=%0d byte=%02h idx=%0d",
                                 got.kind, got.out_byte, got.byte_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                        begin
                            $display("result mismatch: expected kind=%0d byte=%02h idx=%0d len=%0d err=%0d",
                                     want.kind, want.out_byte, want.byte_index,
                                     want.frame_len, want.error_total);
                            $display("                 got      kind=%0d byte=%02h idx=%0d len=%0d err=%0d",
                                     got.kind, got.out_byte, got.byte_index,
                                     got.frame_len, got.error_total);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_results.insert(pending_results.size(), deframe_byte(data_byte));
                n_bytes++;
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg_writes++;
                if (cfg_index == REG_SYNC_BYTE)
                    cur_sync = cfg_data[7:0];
                else if (cfg_index == REG_MAX_LEN)
                    cur_max_len = cfg_data[LEN_BITS-1:0];
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // mostly zero, otherwise short, now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // receiver: one level per step, held for a random number of cycles
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap(rx_idle_pct);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    // called at a rising edge; returns at the edge where the byte transfers
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sync value with junk in the unused upper bits
    function automatic logic [CFG_DAT_BITS-1:0] sync_word(input logic [7:0] s);
        logic [CFG_DAT_BITS-1:0] w;
        w      = CFG_DAT_BITS'($urandom);
        w[7:0] = s;
        return w;
    endfunction

    // header with random spare bits; body only if the length will be accepted
    task automatic send_frame(input logic [LEN_BITS-1:0] len);
        logic [7:0] hdr;
        logic [7:0] b;
        int         i;
        hdr      = 8'($urandom);
        hdr[1:0] = len[9:8];
        send_byte(cur_sync);
        send_byte(hdr);
        send_byte(len[7:0]);
        if (len <= cur_max_len)
            for (i = 0; i < int'(len) + 3; i++)
            begin
                b = 8'($urandom);
                if ($urandom_range(0, 15) == 0)
                    b = cur_sync;
                send_byte(b);
            end
    endtask

    task automatic test_directed_frames();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty payload: check bytes straight after the length
        send_byte(8'hD3); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
        // one payload byte equal to the sync byte
        send_byte(8'hD3); send_byte(8'hFC); send_byte(8'h01); send_byte(8'hD3);
        send_byte(8'hA5); send_byte(8'h0F); send_byte(8'hF0);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_SYNC_BYTE, sync_word(8'h00));
        write_reg(REG_MAX_LEN, 10'd0);
        write_reg(REG_SPARE_A, 10'h3FF);
        write_reg(REG_SPARE_B, 10'h2AA);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        send_byte(8'hD3);
        send_byte(8'h00); send_byte(8'h03); send_byte(8'hFF);   // too long
        send_byte(8'h00); send_byte(8'hFC); send_byte(8'h00);   // zero length fits
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80);
        drain();
    endtask

    // limit rewritten while a header is half received
    task automatic test_midframe_config();
        write_reg(REG_SYNC_BYTE, sync_word(8'hD3));
        write_reg(REG_MAX_LEN, 10'd1023);
        send_byte(8'hD3);
        send_byte(8'h00);
        drain();
        write_reg(REG_MAX_LEN, 10'd4);
        send_byte(8'h05);
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 10;
        rx_hold_req = 1'b1;
        send_frame(10'd4);
        send_frame(10'd2);
        send_frame(10'd9);
        drain();
    endtask

    task automatic random_phase(input logic [7:0] sync, input logic [LEN_BITS-1:0] max_len,
                                input int tx_pct, input int rx_pct, input int n_items);
        int count;
        int pick;
        int cap;
        int extra;
        int i;
        write_reg(REG_SYNC_BYTE, sync_word(sync));
        write_reg(REG_MAX_LEN, max_len);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                cap = ($urandom_range(0, 9) == 0) ? 64 : 16;
                if (cap > int'(cur_max_len))
                    cap = int'(cur_max_len);
                cap = $urandom_range(0, cap);
                send_frame(LEN_BITS'(cap));
                count += cap + 6;
            end
            else if (pick < 80 && cur_max_len != 10'd1023)
            begin
                send_frame(LEN_BITS'($urandom_range(int'(cur_max_len) + 1, 1023)));
                count += 3;
            end
            else if (pick < 88)
            begin
                // header and up to three bytes; if the length is accepted, what follows is taken as payload
                send_byte(cur_sync);
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                extra = $urandom_range(0, 3);
                for (i = 0; i < extra; i++)
                    send_byte(8'($urandom));
                count += 3 + extra;
            end
            else
            begin
                extra = $urandom_range(1, 4);
                for (i = 0; i < extra; i++)
                    send_byte(8'($urandom));
                count += extra;
            end
        end
        drain();
    endtask

    task automatic test_random_stream();
        random_phase(8'hD3, 10'd1023, 0, 0, 110);
        random_phase(8'($urandom), LEN_BITS'($urandom_range(8, 40)), 30, 30, 110);
        random_phase(8'h00, 10'd0, 20, 40, 110);
        random_phase(8'hFF, 10'd1023, 40, 20, 110);
    endtask

    // accepted length with one of the upper length bits set
    task automatic test_long_frame();
        write_reg(REG_SYNC_BYTE, sync_word(8'hD3));
        write_reg(REG_MAX_LEN, 10'd1023);
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        send_frame(10'd300);
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_config_extremes();
        test_midframe_config();
        test_backpressure();
        test_random_stream();
        test_long_frame();
        if (pending_results.size() != 0)
            mismatches++;
        $display("run covered %0d byte transfers, %0d complete frames, %0d rejected headers",
                 n_bytes, n_frames, n_len_errors);
        $display("%0d register writes incl. sync 00/FF and limit 0/1023; %0d mismatches",
                 n_cfg_writes, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
